// ===== sv/k_way_sorted_merge_macros.svh =====
// assertion macros shared by the merge checker
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH

// checked only outside reset
`define KWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/kwm_pkg.sv =====
`timescale 1ns / 1ps
package kwm_pkg;

    localparam int NUM_LISTS   = 8;
    localparam int LIST_DEPTH  = 256;
    localparam int VALUE_WIDTH = 32;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int POS_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = LIST_W + POS_W;
    localparam int L1_N   = (NUM_LISTS + 1) / 2;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    localparam logic [0:0] CFG_LISTS  = 1'd0;
    localparam logic [0:0] CFG_SIGNED = 1'd1;

    typedef struct packed {
        logic              found;
        logic [LIST_W-1:0] idx;
    } t_sel_res;

endpackage

// ===== sv/k_way_sorted_merge.sv =====
// k-way merge of sorted lists held in one 2048-word ram, one head register per list
// load and clear: accepted while idle, no result word
// pop: result word registered after the pair register, the select result and the DONE state
// pop occupancy: SEL and DONE states, then FILL when the popped list refills its head through
// the ram read port; DONE lasts longer while a waiting result word is stalled
// sync active-low reset empties all lists and clears overflow; list contents are kept
`timescale 1ns / 1ps
module k_way_sorted_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [2:0]                      i_list_number,
    input  logic [kwm_pkg::VALUE_WIDTH-1:0] i_value_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [kwm_pkg::VALUE_WIDTH-1:0] o_value_out,
    output logic [2:0]                      o_source_list,
    output logic                            o_valid_res,
    output logic                            o_last,
    output logic                            o_overflow,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [0:0]                      i_cfg_index,
    input  logic [3:0]                      i_cfg_data
);

    import kwm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEL  = 4'b0010,
        S_DONE = 4'b0100,
        S_FILL = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [3:0] r_lists_in_use;
    logic       r_signed;
    logic       r_ovf;

    logic [CNT_W-1:0]       r_fc [NUM_LISTS];
    logic [CNT_W-1:0]       r_rp [NUM_LISTS];
    logic [VALUE_WIDTH-1:0] r_hv [NUM_LISTS];

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_value_out;
    logic [2:0]             r_source_list;
    logic                   r_valid_res;
    logic                   r_last;
    logic                   r_overflow_o;

    logic                   in_acc;
    logic                   out_free;
    logic                   sel_start;
    logic                   sel_done;
    t_sel_res               sel_res;
    logic [VALUE_WIDTH-1:0] keys [NUM_LISTS];
    logic [NUM_LISTS-1:0]   mask;

    logic [LIST_W-1:0]      ld_idx;
    logic                   ld_ok;
    logic                   ld_full;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0]       rp_inc;
    logic                   refill;
    logic                   any_left;
    logic                   finish;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sel_start  = in_acc && (i_req_type == REQ_POP);
    assign finish     = (r_state == S_DONE) && out_free;
    assign o_cfg_ready = 1'b1;

    // heads ordered as unsigned keys; signed mode flips the sign bit
    always_comb begin
        for (int k = 0; k < NUM_LISTS; k++) begin
            keys[k] = r_hv[k] ^ {r_signed, {(VALUE_WIDTH-1){1'b0}}};
            mask[k] = (k < int'(r_lists_in_use)) && (r_rp[k] < r_fc[k]);
        end
    end

    kwm_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sel_start),
        .i_keys  (keys),
        .i_mask  (mask),
        .o_done  (sel_done),
        .o_res   (sel_res)
    );

    // load path
    assign ld_idx    = i_list_number[LIST_W-1:0];
    assign ld_ok     = in_acc && (i_req_type == REQ_LOAD) && (int'(i_list_number) < NUM_LISTS);
    assign ld_full   = (r_fc[ld_idx] == CNT_W'(LIST_DEPTH));
    assign ram_we    = ld_ok && !ld_full;
    assign ram_waddr = {ld_idx, r_fc[ld_idx][POS_W-1:0]};

    // pop finish: advance the winner, fetch its next element
    always_comb begin
        rp_inc   = r_rp[sel_res.idx] + CNT_W'(1);
        refill   = sel_res.found && (rp_inc < r_fc[sel_res.idx]);
        any_left = 1'b0;
        for (int k = 0; k < NUM_LISTS; k++) begin
            if (k < int'(r_lists_in_use)) begin
                if (LIST_W'(k) == sel_res.idx) begin
                    any_left = any_left || (rp_inc < r_fc[k]);
                end else begin
                    any_left = any_left || (r_rp[k] < r_fc[k]);
                end
            end
        end
    end

    assign ram_re    = finish && refill;
    assign ram_raddr = {sel_res.idx, rp_inc[POS_W-1:0]};

    kwm_ram #(
        .DW (VALUE_WIDTH),
        .AW (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (sel_start) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (sel_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (finish) begin
                    n_state = refill ? S_FILL : S_IDLE;
                end
            end
            S_FILL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // head registers: new element of an empty list, or a refill from the ram
    always_ff @(posedge i_clk) begin
        if (ram_we && (r_rp[ld_idx] == r_fc[ld_idx])) begin
            r_hv[ld_idx] <= i_value_in;
        end
        if (r_state == S_FILL) begin
            r_hv[sel_res.idx] <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_lists_in_use <= 4'd2;
            r_signed       <= 1'b0;
            r_ovf          <= 1'b0;
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_fc[k] <= '0;
                r_rp[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LISTS:  r_lists_in_use <= i_cfg_data;
                    CFG_SIGNED: r_signed       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (ld_ok) begin
                if (ld_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fc[ld_idx] <= r_fc[ld_idx] + CNT_W'(1);
                end
            end
            if (in_acc && (i_req_type == REQ_CLEAR)) begin
                r_ovf <= 1'b0;
                for (int k = 0; k < NUM_LISTS; k++) begin
                    r_fc[k] <= '0;
                    r_rp[k] <= '0;
                end
            end
            if (finish && sel_res.found) begin
                r_rp[sel_res.idx] <= rp_inc;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_valid_res  <= sel_res.found;
            r_overflow_o <= r_ovf;
            r_last       <= sel_res.found && !any_left;
            if (sel_res.found) begin
                r_value_out   <= r_hv[sel_res.idx];
                r_source_list <= 3'(sel_res.idx);
            end else begin
                r_value_out   <= '0;
                r_source_list <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_source_list = r_source_list;
    assign o_valid_res   = r_valid_res;
    assign o_last        = r_last;
    assign o_overflow    = r_overflow_o;

endmodule

// ===== sv/kwm_ram.sv =====
`timescale 1ns / 1ps
module kwm_ram #(
    parameter int DW = 32,
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/kwm_sel.sv =====
`timescale 1ns / 1ps
module kwm_sel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [kwm_pkg::VALUE_WIDTH-1:0] i_keys [kwm_pkg::NUM_LISTS],
    input  logic [kwm_pkg::NUM_LISTS-1:0]   i_mask,
    output logic                           o_done,
    output kwm_pkg::t_sel_res              o_res
);

    import kwm_pkg::*;

    typedef struct packed {
        logic                   found;
        logic [LIST_W-1:0]      idx;
        logic [VALUE_WIDTH-1:0] key;
    } t_cand;

    // a wins ties, so a must hold the lower list index
    function automatic t_cand pick(t_cand a, t_cand b);
        t_cand w;
        w = a;
        if (b.found && (!a.found || b.key < a.key)) begin
            w = b;
        end
        return w;
    endfunction

    t_cand    n_l1 [L1_N];
    t_cand    r_l1 [L1_N];
    logic     r_l1_v;
    t_cand    n_fin;
    t_sel_res r_res;
    logic     r_done;

    // first level: pairs of heads
    always_comb begin
        t_cand a;
        t_cand b;
        for (int j = 0; j < L1_N; j++) begin
            a.found = i_mask[2*j];
            a.idx   = LIST_W'(2*j);
            a.key   = i_keys[2*j];
            if (2*j + 1 < NUM_LISTS) begin
                b.found = i_mask[2*j+1];
                b.idx   = LIST_W'(2*j + 1);
                b.key   = i_keys[2*j+1];
                n_l1[j] = pick(a, b);
            end else begin
                b       = a;
                n_l1[j] = a;
            end
        end
    end

    // second level: walk the pair winners in index order
    always_comb begin
        n_fin = r_l1[0];
        for (int j = 1; j < L1_N; j++) begin
            n_fin = pick(n_fin, r_l1[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_l1 <= n_l1;
        end
        if (r_l1_v) begin
            r_res.found <= n_fin.found;
            r_res.idx   <= n_fin.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_l1_v <= i_start;
            r_done <= r_l1_v;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== sv/kwm_checker.sv =====
`timescale 1ns / 1ps
`include "k_way_sorted_merge_macros.svh"
module kwm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [1:0]                      i_req_type,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [kwm_pkg::VALUE_WIDTH-1:0] o_value_out,
    input logic [2:0]                      o_source_list,
    input logic                            o_valid_res,
    input logic                            o_last
);

    import kwm_pkg::*;

    // a stalled result word holds
    `KWM_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value_out) && $stable(o_source_list) && $stable(o_last)), "stalled result word changed")

    // an empty pop reports zero fields
    `KWM_ASSERT(a_empty_zero, (o_out_valid && !o_valid_res) |-> (o_value_out == '0 && o_source_list == '0 && !o_last), "empty pop with nonzero fields")

    `KWM_ASSERT(a_last_valid, (o_out_valid && o_last) |-> o_valid_res, "last flag on an empty pop")

    // a pop occupies the block for the following cycle
    `KWM_ASSERT(a_pop_busy, (i_in_valid && !o_in_stall && i_req_type == REQ_POP) |=> o_in_stall, "pop did not stall the input")

    `KWM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall), "block not idle after reset")

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);

// ===== test/k_way_sorted_merge_tb.sv =====
`timescale 1ns / 1ps
module k_way_sorted_merge_tb;
    import kwm_pkg::*;

    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [31:0] SIGN_FLIP     = 32'h8000_0000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_WORDS  = 200;
    localparam int          TIMEOUT_NS    = 5_000_000;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  src;
        logic        vld;
        logic        lst;
        logic        ovf;
    } t_pop_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = REQ_LOAD;
    logic [2:0]  i_list_number = '0;
    logic [31:0] i_value_in = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [0:0]  i_cfg_index = CFG_LISTS;
    logic [3:0]  i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_value_out;
    logic [2:0]  o_source_list;
    logic        o_valid_res;
    logic        o_last;
    logic        o_overflow;
    logic        o_cfg_ready;

    k_way_sorted_merge DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_list_number (i_list_number),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_out   (o_value_out),
        .o_source_list (o_source_list),
        .o_valid_res   (o_valid_res),
        .o_last        (o_last),
        .o_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // merge model state
    logic [31:0]  list_mem [NUM_LISTS][LIST_DEPTH];
    int unsigned  fill_cnt [NUM_LISTS];
    int unsigned  rd_pos [NUM_LISTS];
    bit           sticky_ovf;
    logic [3:0]   mode_lists;
    bit           mode_signed;
    t_pop_result  pops_due [$];

    // stimulus state
    logic [31:0]  next_key [NUM_LISTS];
    int unsigned  burst_left = 0;
    bit           sender_idles = 1'b1;
    int unsigned  stall_mode = 0;
    logic [7:0]   stall_phase = '0;

    // statistics
    int unsigned  words_sent = 0;
    int unsigned  n_loads = 0;
    int unsigned  n_pops = 0;
    int unsigned  n_clears = 0;
    int unsigned  n_unused = 0;
    int unsigned  mode_writes = 0;
    int unsigned  results_seen = 0;
    int unsigned  empty_seen = 0;
    int unsigned  last_seen = 0;
    int unsigned  ovf_seen = 0;
    int unsigned  bad_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned lists_taking_part();
        return (mode_lists > NUM_LISTS) ? NUM_LISTS : mode_lists;
    endfunction

    function automatic int unsigned values_waiting();
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < lists_taking_part(); k++)
            sum += fill_cnt[k] - rd_pos[k];
        return sum;
    endfunction

    function automatic void merge_reset();
        for (int k = 0; k < NUM_LISTS; k++) begin
            fill_cnt[k] = 0;
            rd_pos[k] = 0;
        end
        sticky_ovf = 1'b0;
        mode_lists = 4'd2;
        mode_signed = 1'b0;
    endfunction

    // advance the merge model by one accepted word, queue the pop result if any
    function automatic void merge_apply(logic [1:0] req, logic [2:0] ln, logic [31:0] v);
        int unsigned n;
        int unsigned best;
        bit          found;
        bit          any_left;
        logic [31:0] key;
        logic [31:0] best_key;
        t_pop_result r;
        if (req != REQ_UNUSED)
            words_sent++;
        case (req)
            REQ_LOAD: begin
                n_loads++;
                if (ln < NUM_LISTS) begin
                    if (fill_cnt[ln] >= LIST_DEPTH) begin
                        sticky_ovf = 1'b1;
                    end else begin
                        list_mem[ln][fill_cnt[ln]] = v;
                        fill_cnt[ln]++;
                    end
                end
            end
            REQ_CLEAR: begin
                n_clears++;
                for (int k = 0; k < NUM_LISTS; k++) begin
                    fill_cnt[k] = 0;
                    rd_pos[k] = 0;
                end
                sticky_ovf = 1'b0;
            end
            REQ_POP: begin
                n_pops++;
                n = lists_taking_part();
                found = 1'b0;
                best = 0;
                best_key = '0;
                for (int k = 0; k < n; k++) begin
                    if (rd_pos[k] < fill_cnt[k]) begin
                        key = list_mem[k][rd_pos[k]] ^ (mode_signed ? SIGN_FLIP : 32'd0);
                        if (!found || key < best_key) begin
                            found = 1'b1;
                            best = k;
                            best_key = key;
                        end
                    end
                end
                r.value = found ? list_mem[best][rd_pos[best]] : 32'd0;
                r.src = found ? best[2:0] : 3'd0;
                r.vld = found;
                any_left = 1'b0;
                if (found) begin
                    rd_pos[best]++;
                    for (int k = 0; k < n; k++)
                        if (rd_pos[k] < fill_cnt[k])
                            any_left = 1'b1;
                end
                r.lst = found && !any_left;
                r.ovf = sticky_ovf;
                pops_due.push_back(r);
            end
            default: n_unused++;
        endcase
    endfunction

    // one input word; bursts end in a random gap when the sender idles
    task automatic send_word(input logic [1:0] req, input logic [2:0] ln, input logic [31:0] v);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_list_number <= ln;
        i_value_in <= v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        merge_apply(req, ln, v);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idles ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic load_word(input logic [2:0] ln, input logic [31:0] v);
        send_word(REQ_LOAD, ln, v);
    endtask

    task automatic pop_word();
        send_word(REQ_POP, 3'($urandom_range(0, 7)), $urandom());
    endtask

    task automatic clear_lists();
        for (int k = 0; k < NUM_LISTS; k++)
            next_key[k] = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom() >> $urandom_range(2, 31);
        send_word(REQ_CLEAR, 3'($urandom_range(0, 7)), $urandom());
    endtask

    // drop valid, wait for every result, then let loads and clears finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pops_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [3:0] lists, input bit sgn);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LISTS;
        i_cfg_data <= lists;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        mode_lists = lists;
        // upper data bits are don't care for the compare mode
        i_cfg_index <= CFG_SIGNED;
        i_cfg_data <= {3'($urandom_range(0, 7)), sgn};
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        mode_signed = sgn;
        i_cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= ($urandom_range(0, 99) < 75);
            default: i_out_stall <= (stall_phase[2:0] >= 3'd5);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_pop_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_valid_res !== 1'b1)
                empty_seen++;
            if (o_last === 1'b1)
                last_seen++;
            if (o_overflow === 1'b1)
                ovf_seen++;
            if (pops_due.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected result word: value %h list %0d valid %0b last %0b ovf %0b",
                             o_value_out, o_source_list, o_valid_res, o_last, o_overflow);
            end else begin
                w = pops_due.pop_front();
                if (o_value_out !== w.value || o_source_list !== w.src ||
                    o_valid_res !== w.vld || o_last !== w.lst || o_overflow !== w.ovf) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display({"mismatch: expected value %h list %0d valid %0b last %0b ovf %0b,",
                                  " got value %h list %0d valid %0b last %0b ovf %0b"},
                                 w.value, w.src, w.vld, w.lst, w.ovf,
                                 o_value_out, o_source_list, o_valid_res, o_last, o_overflow);
                end
            end
        end
    end

    // unsigned order, ties, empty pops and the unused request code
    task automatic test_edge_values();
        set_mode(4'd8, 1'b0);
        pop_word();
        load_word(3'd0, 32'h0000_0000);
        load_word(3'd1, 32'hFFFF_FFFF);
        load_word(3'd2, 32'h8000_0000);
        load_word(3'd3, 32'h7FFF_FFFF);
        load_word(3'd7, 32'h0000_0005);
        load_word(3'd4, 32'h0000_0005);
        load_word(3'd5, 32'h0000_0001);
        send_word(REQ_UNUSED, 3'd6, 32'hFFFF_FFFF);
        repeat (8) pop_word();
    endtask

    task automatic test_signed_order();
        settle();
        set_mode(4'd8, 1'b1);
        clear_lists();
        load_word(3'd0, 32'h8000_0000);
        load_word(3'd0, 32'hFFFF_FFFF);
        load_word(3'd1, 32'h7FFF_FFFF);
        load_word(3'd2, 32'h0000_0000);
        load_word(3'd2, 32'h0000_0001);
        load_word(3'd6, 32'h8000_0000);
        repeat (7) pop_word();
    endtask

    // lists beyond the active count keep their data until the count grows
    task automatic test_lists_in_use();
        settle();
        set_mode(4'd3, 1'b0);
        clear_lists();
        for (int k = 0; k < 6; k++)
            load_word(3'(k), 32'(10 - k));
        repeat (4) pop_word();
        settle();
        set_mode(4'd15, 1'b1);
        repeat (4) pop_word();
        settle();
        set_mode(4'd0, 1'b0);
        load_word(3'd0, 32'h0000_0009);
        pop_word();
        settle();
        set_mode(4'd1, 1'b0);
        pop_word();
    endtask

    task automatic test_clear();
        settle();
        set_mode(4'd2, 1'b0);
        load_word(3'd0, 32'h0000_0100);
        load_word(3'd1, 32'h0000_0040);
        pop_word();
        clear_lists();
        pop_word();
        load_word(3'd1, 32'h1234_5678);
        pop_word();
    endtask

    // fill one list, overflow it, and check popped slots stay used until a clear
    task automatic test_full_list();
        logic [31:0] v;
        settle();
        set_mode(4'd1, 1'b0);
        clear_lists();
        for (int i = 0; i < LIST_DEPTH; i++) begin
            v = 32'(i) * 32'h00FF_FFFF;
            load_word(3'd0, v);
        end
        load_word(3'd0, 32'hFFFF_FFFF);
        load_word(3'd1, 32'h0000_0001);
        repeat (10) pop_word();
        load_word(3'd0, 32'hFFFF_FFFF);
        repeat (LIST_DEPTH - 10 + 1) pop_word();
        clear_lists();
        pop_word();
    endtask

    task automatic noise_word();
        case ($urandom_range(0, 3))
            0: load_word(3'($urandom_range(0, 7)), $urandom());
            1: pop_word();
            2: send_word(REQ_UNUSED, 3'($urandom_range(0, 7)), $urandom());
            default: clear_lists();
        endcase
    endtask

    // mostly ascending per-list loads, then pops that drain the active lists
    task automatic merge_round();
        int unsigned lim;
        int unsigned ln;
        int unsigned n_pop;
        logic [31:0] key;
        lim = lists_taking_part();
        repeat ($urandom_range(1, 30)) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_word();
            end else begin
                ln = (lim != 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, lim - 1)
                                                             : $urandom_range(0, 7);
                key = next_key[ln] + ($urandom() >> $urandom_range(8, 31));
                if (key < next_key[ln])
                    key = 32'hFFFF_FFFF;
                next_key[ln] = key;
                load_word(3'(ln), key ^ (mode_signed ? SIGN_FLIP : 32'd0));
            end
        end
        n_pop = values_waiting() + $urandom_range(0, 2);
        repeat (n_pop) begin
            if ($urandom_range(0, 9) == 0)
                noise_word();
            pop_word();
        end
        if ($urandom_range(0, 3) == 0)
            clear_lists();
    endtask

    task automatic test_random_merges();
        int unsigned start_words;
        int unsigned pick;
        logic [3:0]  lists;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            settle();
            pick = $urandom_range(0, 11);
            if (pick == 0)
                lists = 4'd0;
            else if (pick == 1)
                lists = 4'($urandom_range(NUM_LISTS + 1, 15));
            else
                lists = 4'($urandom_range(1, NUM_LISTS));
            set_mode(lists, 1'($urandom_range(0, 1)));
            stall_mode = $urandom_range(0, 3);
            sender_idles = ($urandom_range(0, 3) != 0);
            clear_lists();
            repeat ($urandom_range(1, 4)) merge_round();
        end
        stall_mode = 0;
        sender_idles = 1'b1;
    endtask

    initial begin
        merge_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stall_mode = 1;
        test_edge_values();
        test_signed_order();
        test_lists_in_use();
        test_clear();
        stall_mode = 3;
        test_full_list();
        test_random_merges();
        settle();
        $display("covered %0d loads, %0d pops, %0d clears, %0d unused codes, %0d mode settings",
                 n_loads, n_pops, n_clears, n_unused, mode_writes);
        $display("checked %0d results: %0d empty, %0d last, %0d with overflow, %0d mismatches",
                 results_seen, empty_seen, last_seen, ovf_seen, bad_count);
        if (bad_count == 0 && pops_due.size() == 0)
            $display("k_way_sorted_merge test passed");
        else
            $display("k_way_sorted_merge test failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("k_way_sorted_merge test failed");
        $finish;
    end

endmodule
